// ===== sv/asav_pkg.sv =====
// Shared constants, types and the arctangent table of the angular sector artifact block.
package asav_pkg;

    localparam int DIM_MAX      = 1024;
    localparam int CORDIC_STEPS = 24;
    localparam int NSTEP        = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

    localparam int IDX_W   = 10;
    localparam int IDX_MAX = ((DIM_MAX - 1) > 1023) ? 1023 : (DIM_MAX - 1);
    localparam int SPC_W   = 16;
    localparam int OFF_W   = 32;
    localparam int PROD_W  = IDX_W + SPC_W;
    localparam int POS_W   = OFF_W + 2;
    localparam int CRD_W   = POS_W + 3;
    localparam int Z_W     = 26;
    localparam int ANG_W   = 25;
    localparam int WID_W   = 25;
    localparam int TOT_W   = WID_W + 1;
    localparam int LVL_W   = 16;
    localparam int DAT_W   = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_OFF_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPC_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPC_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRT_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRK_W   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRT_LVL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRK_LVL = 3'd7;

    localparam logic signed [Z_W-1:0] DEG90  = 26'sd5898240;
    localparam logic [ANG_W-1:0]      DEG180 = 25'd11796480;
    localparam logic [ANG_W-1:0]      DEG360 = 25'd23592960;

    // Item sideband that rides along the pipeline.
    typedef struct packed {
        logic                    valid;
        logic signed [DAT_W-1:0] density;
        logic signed [DAT_W-1:0] artifact;
    } t_side;

    typedef struct packed {
        logic center;
        logic neg_x;
    } t_flags;

    // atan(2^-i) in 1/65536 degree, rounded to nearest.
    function automatic logic signed [Z_W-1:0] step_angle(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:  a = 26'sd2949120;
            1:  a = 26'sd1740967;
            2:  a = 26'sd919879;
            3:  a = 26'sd466945;
            4:  a = 26'sd234379;
            5:  a = 26'sd117304;
            6:  a = 26'sd58666;
            7:  a = 26'sd29335;
            8:  a = 26'sd14668;
            9:  a = 26'sd7334;
            10: a = 26'sd3667;
            11: a = 26'sd1833;
            12: a = 26'sd917;
            13: a = 26'sd458;
            14: a = 26'sd229;
            15: a = 26'sd115;
            16: a = 26'sd57;
            17: a = 26'sd29;
            18: a = 26'sd14;
            19: a = 26'sd7;
            20: a = 26'sd4;
            21: a = 26'sd2;
            22: a = 26'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/asav_pos.sv =====
// In-plane voxel position: index times spacing, then plus origin offset (two stages).
module asav_pos (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  asav_pkg::t_side                   i_side,
    input  logic        [asav_pkg::IDX_W-1:0] i_col,
    input  logic        [asav_pkg::IDX_W-1:0] i_row,
    input  logic signed [asav_pkg::OFF_W-1:0] i_off_x,
    input  logic signed [asav_pkg::OFF_W-1:0] i_off_y,
    input  logic        [asav_pkg::SPC_W-1:0] i_spc_x,
    input  logic        [asav_pkg::SPC_W-1:0] i_spc_y,
    output asav_pkg::t_side                   o_side,
    output logic signed [asav_pkg::POS_W-1:0] o_px,
    output logic signed [asav_pkg::POS_W-1:0] o_py
);
    import asav_pkg::*;

    logic [IDX_W-1:0]  col_c;
    logic [IDX_W-1:0]  row_c;
    t_side             r_side_a;
    t_side             r_side_b;
    logic [PROD_W-1:0] r_prod_x;
    logic [PROD_W-1:0] r_prod_y;
    logic signed [POS_W-1:0] r_px;
    logic signed [POS_W-1:0] r_py;

    // clamp indices past the slice edge
    assign col_c = (i_col > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : i_col;
    assign row_c = (i_row > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : i_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_a <= '0;
            r_side_b <= '0;
        end else if (i_en) begin
            r_side_a <= i_side;
            r_side_b <= r_side_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x <= PROD_W'(col_c) * PROD_W'(i_spc_x);
            r_prod_y <= PROD_W'(row_c) * PROD_W'(i_spc_y);
            r_px     <= POS_W'(i_off_x) + $signed({{(POS_W-PROD_W){1'b0}}, r_prod_x});
            r_py     <= POS_W'(i_off_y) + $signed({{(POS_W-PROD_W){1'b0}}, r_prod_y});
        end
    end

    assign o_side = r_side_b;
    assign o_px   = r_px;
    assign o_py   = r_py;

endmodule

// ===== sv/asav_cordic.sv =====
// Vectoring CORDIC polar angle, one micro-rotation per pipeline stage.
module asav_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  asav_pkg::t_side                   i_side,
    input  logic signed [asav_pkg::POS_W-1:0] i_px,
    input  logic signed [asav_pkg::POS_W-1:0] i_py,
    output asav_pkg::t_side                   o_side,
    output logic        [asav_pkg::ANG_W-1:0] o_ang
);
    import asav_pkg::*;

    logic signed [CRD_W-1:0] x_e;
    logic signed [CRD_W-1:0] y_e;
    logic signed [CRD_W-1:0] cx0;
    logic signed [CRD_W-1:0] cy0;
    logic signed [Z_W-1:0]   z0;
    t_flags                  flg0;

    logic signed [CRD_W-1:0] r_cx   [0:NSTEP];
    logic signed [CRD_W-1:0] r_cy   [0:NSTEP];
    logic signed [Z_W-1:0]   r_z    [0:NSTEP];
    t_flags                  r_flg  [0:NSTEP];
    t_side                   r_side [0:NSTEP];

    logic signed [Z_W:0]     z_fin;
    logic [ANG_W-1:0]        ang_c;
    logic [ANG_W-1:0]        r_ang;
    t_side                   r_side_o;

    assign x_e = CRD_W'(i_px);
    assign y_e = CRD_W'(i_py);

    // turn the left half plane into the right one
    always_comb begin
        flg0.center = (i_px == '0) && (i_py == '0);
        flg0.neg_x  = (i_py == '0) && (i_px < 0);
        if (i_px > 0) begin
            cx0 = x_e;
            cy0 = y_e;
            z0  = '0;
        end else if (i_py > 0) begin
            cx0 = y_e;
            cy0 = -x_e;
            z0  = DEG90;
        end else begin
            cx0 = -y_e;
            cy0 = x_e;
            z0  = -DEG90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]  <= cx0;
            r_cy[0]  <= cy0;
            r_z[0]   <= z0;
            r_flg[0] <= flg0;
        end
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k+1] <= '0;
            end else if (i_en) begin
                r_side[k+1] <= r_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flg[k+1] <= r_flg[k];
                if (r_cy[k] >= 0) begin
                    r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                    r_z[k+1]  <= r_z[k] + step_angle(k);
                end else begin
                    r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                    r_z[k+1]  <= r_z[k] - step_angle(k);
                end
            end
        end
    end

    // shift to 0..360 degrees, clamp, apply the on-axis cases
    always_comb begin
        z_fin = (Z_W+1)'(r_z[NSTEP]) + $signed({2'b00, DEG180});
        if (r_flg[NSTEP].center) begin
            ang_c = DEG180;
        end else if (r_flg[NSTEP].neg_x) begin
            ang_c = DEG360;
        end else if (z_fin < 0) begin
            ang_c = '0;
        end else if (z_fin > $signed({2'b00, DEG360})) begin
            ang_c = DEG360;
        end else begin
            ang_c = z_fin[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_o <= '0;
        end else if (i_en) begin
            r_side_o <= r_side[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= ang_c;
        end
    end

    assign o_side = r_side_o;
    assign o_ang  = r_ang;

endmodule

// ===== sv/asav_mod.sv =====
// Pipelined restoring remainder of the angle by the combined sector width.
module asav_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  asav_pkg::t_side            i_side,
    input  logic [asav_pkg::ANG_W-1:0] i_ang,
    input  logic [asav_pkg::TOT_W-1:0] i_total,
    output asav_pkg::t_side            o_side,
    output logic [asav_pkg::ANG_W-1:0] o_rem
);
    import asav_pkg::*;

    localparam int D_W = TOT_W + ANG_W;

    logic [ANG_W-1:0] r_rem  [0:ANG_W];
    t_side            r_side [0:ANG_W];

    assign r_rem[0]  = i_ang;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < ANG_W; k++) begin : g_bit
        logic [D_W-1:0] div_sh;
        logic [D_W-1:0] rem_e;

        // one quotient bit per stage, most significant first
        assign div_sh = D_W'(i_total) << (ANG_W - 1 - k);
        assign rem_e  = D_W'(r_rem[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k+1] <= '0;
            end else if (i_en) begin
                r_side[k+1] <= r_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_e >= div_sh) begin
                    r_rem[k+1] <= ANG_W'(rem_e - div_sh);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                end
            end
        end
    end

    assign o_side = r_side[ANG_W];
    assign o_rem  = r_rem[ANG_W];

endmodule

// ===== sv/angular_sector_artifact_voxel_top.sv =====
// Top level of the angular sector (windmill) artifact block: config, pipeline, output skid.
//
//  channel   direction  handshake                 payload
//  s (voxel) in         i_s_tvalid / o_s_tready   i_s_tdata: column, row, density, artifact
//  m (result)out        o_m_tvalid / i_m_tready   o_m_tdata: density, artifact, level, dark
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One voxel enters per cycle while the skid is empty; the path runs through the position
// stages, the CORDIC stages, the angle register, the remainder and the output register.
// The CORDIC micro-rotations and the remainder bits each own one stage.
// Reset is synchronous, active low; it clears all valid bits and loads the
// register defaults (spacings 256, everything else zero).
// A stalled output parks one item in the skid register; the pipeline then holds
// until the skid drains, so nothing is lost or repeated. Config is always ready.
module angular_sector_artifact_voxel_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // bits 0..9 column_index, 10..19 row_index, 20..35 density_in,
    // 36..51 prior_artifact, 52..55 zero
    input  logic [asav_pkg::S_TDATA_W-1:0]        i_s_tdata,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // bits 0..15 density_out, 16..31 artifact_out, 32..47 pattern_level,
    // 48 in_dark, 49..55 zero
    output logic [asav_pkg::M_TDATA_W-1:0]        o_m_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [asav_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [asav_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    import asav_pkg::*;

    localparam int RES_W = 2 * DAT_W + LVL_W + 1;

    // configuration registers
    logic signed [OFF_W-1:0] r_off_x;
    logic signed [OFF_W-1:0] r_off_y;
    logic [SPC_W-1:0]        r_spc_x;
    logic [SPC_W-1:0]        r_spc_y;
    logic [WID_W-1:0]        r_brt_w;
    logic [WID_W-1:0]        r_drk_w;
    logic signed [LVL_W-1:0] r_brt_lvl;
    logic signed [LVL_W-1:0] r_drk_lvl;
    logic [TOT_W-1:0]        total;

    // pipeline
    logic                    en;
    t_side                   side_in;
    t_side                   side_pos;
    t_side                   side_ang;
    t_side                   side_rem;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [ANG_W-1:0]        ang;
    logic [ANG_W-1:0]        rem;

    // result forming
    logic                    dark;
    logic signed [LVL_W-1:0] level;
    logic signed [DAT_W:0]   sum_d;
    logic signed [DAT_W:0]   sum_a;
    logic [DAT_W-1:0]        sat_d;
    logic [DAT_W-1:0]        sat_a;
    logic [RES_W-1:0]        res;

    // output register and skid
    logic                    r_o_v;
    logic [RES_W-1:0]        r_o_d;
    logic                    r_sk_v;
    logic [RES_W-1:0]        r_sk_d;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_spc_x   <= SPC_W'(256);
            r_spc_y   <= SPC_W'(256);
            r_brt_w   <= '0;
            r_drk_w   <= '0;
            r_brt_lvl <= '0;
            r_drk_lvl <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OFF_X:   r_off_x   <= i_cfg_data;
                REG_OFF_Y:   r_off_y   <= i_cfg_data;
                REG_SPC_X:   r_spc_x   <= i_cfg_data[SPC_W-1:0];
                REG_SPC_Y:   r_spc_y   <= i_cfg_data[SPC_W-1:0];
                REG_BRT_W:   r_brt_w   <= i_cfg_data[WID_W-1:0];
                REG_DRK_W:   r_drk_w   <= i_cfg_data[WID_W-1:0];
                REG_BRT_LVL: r_brt_lvl <= i_cfg_data[LVL_W-1:0];
                REG_DRK_LVL: r_drk_lvl <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign total = TOT_W'(r_brt_w) + TOT_W'(r_drk_w);

    // advance the whole pipeline while the skid is empty
    assign en         = !r_sk_v;
    assign o_s_tready = en;

    assign side_in.valid    = i_s_tvalid;
    assign side_in.density  = i_s_tdata[35:20];
    assign side_in.artifact = i_s_tdata[51:36];

    asav_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (side_in),
        .i_col   (i_s_tdata[9:0]),
        .i_row   (i_s_tdata[19:10]),
        .i_off_x (r_off_x),
        .i_off_y (r_off_y),
        .i_spc_x (r_spc_x),
        .i_spc_y (r_spc_y),
        .o_side  (side_pos),
        .o_px    (px),
        .o_py    (py)
    );

    asav_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (side_pos),
        .i_px    (px),
        .i_py    (py),
        .o_side  (side_ang),
        .o_ang   (ang)
    );

    asav_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (side_ang),
        .i_ang   (ang),
        .i_total (total),
        .o_side  (side_rem),
        .o_rem   (rem)
    );

    // pick the sector level; a zero combined width adds nothing
    always_comb begin
        dark  = (total != '0) && (TOT_W'(rem) >= TOT_W'(r_brt_w));
        if (total == '0) begin
            level = '0;
        end else if (dark) begin
            level = r_drk_lvl;
        end else begin
            level = r_brt_lvl;
        end
        sum_d = (DAT_W+1)'(side_rem.density)  + (DAT_W+1)'(level);
        sum_a = (DAT_W+1)'(side_rem.artifact) + (DAT_W+1)'(level);
        if (sum_d[DAT_W] != sum_d[DAT_W-1]) begin
            sat_d = sum_d[DAT_W] ? {1'b1, {(DAT_W-1){1'b0}}} : {1'b0, {(DAT_W-1){1'b1}}};
        end else begin
            sat_d = sum_d[DAT_W-1:0];
        end
        if (sum_a[DAT_W] != sum_a[DAT_W-1]) begin
            sat_a = sum_a[DAT_W] ? {1'b1, {(DAT_W-1){1'b0}}} : {1'b0, {(DAT_W-1){1'b1}}};
        end else begin
            sat_a = sum_a[DAT_W-1:0];
        end
        res = {dark, level, sat_a, sat_d};
    end

    // output register with a one-deep skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else begin
            if (!r_o_v || i_m_tready) begin
                if (r_sk_v) begin
                    r_o_v  <= 1'b1;
                    r_sk_v <= 1'b0;
                end else begin
                    r_o_v  <= side_rem.valid;
                end
            end else if (en && side_rem.valid) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || i_m_tready) begin
            r_o_d <= r_sk_v ? r_sk_d : res;
        end else if (en && side_rem.valid) begin
            r_sk_d <= res;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = M_TDATA_W'(r_o_d);

endmodule
